// File: hdl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies; imported by the front, queue, back and top modules of the block.
package u8u16_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO_B = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI_B = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN3      = 21'h000800;
  localparam logic [CP_W-1:0] MIN4      = 21'h010000;

  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // Upper six bits of a high / low surrogate unit
  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;

  typedef enum logic [1:0] {
    ENT_UNIT  = 2'd0,   // one result: code point or BMP unit
    ENT_PAIR  = 2'd1,   // two results: surrogate pair
    ENT_ERROR = 2'd2    // one error result
  } ent_kind_t;

  typedef struct packed {
    ent_kind_t       kind;
    logic [CP_W-1:0] cp;
    logic            eot;
  } ent_t;

endpackage

// File: hdl/u8u16_front.sv
// Front end: accepts UTF-8 bytes, tracks the partial sequence, validates,
// and pushes one job per completed code point, or an error job at end of text. Uses u8u16_pkg.
module u8u16_front import u8u16_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       q_full,
  output logic       q_push,
  output ent_t       q_wr_ent
);

  logic            mode_r;
  logic [CP_W-1:0] partial_r, partial_nxt;
  logic [1:0]      remain_r, remain_nxt;
  logic [2:0]      seq_len_r, seq_len_nxt;
  logic            discard_r, discard_nxt;

  logic            beat;
  logic [CP_W-1:0] cp_acc;
  logic            cp_bad;

  assign in_tready = ~q_full;
  assign beat      = in_tvalid & in_tready;
  assign cp_acc    = {partial_r[CP_W-7:0], in_tdata[5:0]};

  always_comb begin
    cp_bad = 1'b0;
    if (seq_len_r == 3'd3 && cp_acc < MIN3) cp_bad = 1'b1;
    if (seq_len_r == 3'd4 && cp_acc < MIN4) cp_bad = 1'b1;
    if (cp_acc > CP_MAX) cp_bad = 1'b1;
    if (cp_acc >= SURR_LO_B && cp_acc <= SURR_HI_B) cp_bad = 1'b1;
  end

  always_comb begin
    partial_nxt   = partial_r;
    remain_nxt    = remain_r;
    seq_len_nxt   = seq_len_r;
    discard_nxt   = discard_r;
    q_push        = 1'b0;
    q_wr_ent.kind = ENT_UNIT;
    q_wr_ent.cp   = '0;
    q_wr_ent.eot  = in_tlast;
    if (beat) begin
      if (discard_r) begin
        // dropping bytes until the text ends
      end else if (remain_r == 2'd0) begin
        if (in_tdata <= ASCII_MAX) begin
          q_push      = 1'b1;
          q_wr_ent.cp = {{(CP_W-8){1'b0}}, in_tdata};
        end else if (in_tdata >= LEAD2_MIN && in_tdata <= LEAD2_MAX) begin
          partial_nxt = {{(CP_W-5){1'b0}}, in_tdata[4:0]};
          remain_nxt  = 2'd1;
          seq_len_nxt = 3'd2;
        end else if (in_tdata >= LEAD3_MIN && in_tdata <= LEAD3_MAX) begin
          partial_nxt = {{(CP_W-4){1'b0}}, in_tdata[3:0]};
          remain_nxt  = 2'd2;
          seq_len_nxt = 3'd3;
        end else if (in_tdata >= LEAD4_MIN && in_tdata <= LEAD4_MAX) begin
          partial_nxt = {{(CP_W-3){1'b0}}, in_tdata[2:0]};
          remain_nxt  = 2'd3;
          seq_len_nxt = 3'd4;
        end else begin
          discard_nxt = 1'b1;
        end
      end else if ((in_tdata & CONT_MASK) != CONT_TAG) begin
        discard_nxt = 1'b1;
      end else begin
        partial_nxt = cp_acc;
        remain_nxt  = remain_r - 2'd1;
        if (remain_r == 2'd1) begin
          if (cp_bad) begin
            discard_nxt = 1'b1;
          end else begin
            q_push      = 1'b1;
            q_wr_ent.cp = cp_acc;
            partial_nxt = '0;
            seq_len_nxt = 3'd0;
          end
        end
      end
      // Code points beyond the BMP (MIN4 and up) split into a pair in UTF-16 mode
      if (q_push && mode_r && (q_wr_ent.cp >= MIN4)) q_wr_ent.kind = ENT_PAIR;
      // End of text: error if nothing valid completed here, then clear all
      if (in_tlast) begin
        if (!q_push) begin
          q_push        = 1'b1;
          q_wr_ent.kind = ENT_ERROR;
          q_wr_ent.cp   = '0;
        end
        partial_nxt = '0;
        remain_nxt  = 2'd0;
        seq_len_nxt = 3'd0;
        discard_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b1;
      partial_r <= '0;
      remain_r  <= 2'd0;
      seq_len_r <= 3'd0;
      discard_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      partial_r <= partial_nxt;
      remain_r  <= remain_nxt;
      seq_len_r <= seq_len_nxt;
      discard_r <= discard_nxt;
    end
  end

endmodule

// File: hdl/u8u16_queue.sv
// Small job FIFO between front and back end.
// Uses u8u16_pkg for the job type.
module u8u16_queue import u8u16_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ent_t wr_ent,
  input  logic pop,
  output ent_t rd_ent,
  output logic full,
  output logic empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ent_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_ent  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: hdl/u8u16_back.sv
// Back end: pops jobs and drives the registered result stream, splitting
// supplementary code points into surrogate pairs. Uses u8u16_pkg.
module u8u16_back import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ent_t        q_rd_ent,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tlast,
  output logic [1:0]  out_tuser
);

  logic            out_valid_r, out_valid_nxt;
  logic [CP_W-1:0] unit_r, unit_nxt;
  logic            err_r, err_nxt;
  logic            last_r, last_nxt;
  logic            done_r, done_nxt;
  logic            pend_r, pend_nxt;
  logic [9:0]      pend_lo_r, pend_lo_nxt;
  logic            pend_eot_r, pend_eot_nxt;

  logic            load;
  logic [19:0]     sup_off;

  assign load    = ~out_valid_r | out_tready;
  assign sup_off = q_rd_ent.cp[19:0] - MIN4[19:0];

  always_comb begin
    out_valid_nxt = out_valid_r;
    unit_nxt      = unit_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    done_nxt      = done_r;
    pend_nxt      = pend_r;
    pend_lo_nxt   = pend_lo_r;
    pend_eot_nxt  = pend_eot_r;
    q_pop         = 1'b0;
    if (load) begin
      if (pend_r) begin
        // low half of a pair
        out_valid_nxt = 1'b1;
        unit_nxt      = {{(CP_W-16){1'b0}}, LO_SURR_TAG, pend_lo_r};
        err_nxt       = 1'b0;
        last_nxt      = 1'b1;
        done_nxt      = pend_eot_r;
        pend_nxt      = 1'b0;
      end else if (!q_empty) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        case (q_rd_ent.kind)
          ENT_UNIT: begin
            unit_nxt = q_rd_ent.cp;
            err_nxt  = 1'b0;
            last_nxt = 1'b1;
            done_nxt = q_rd_ent.eot;
          end
          ENT_PAIR: begin
            unit_nxt     = {{(CP_W-16){1'b0}}, HI_SURR_TAG, sup_off[19:10]};
            err_nxt      = 1'b0;
            last_nxt     = 1'b0;
            done_nxt     = 1'b0;
            pend_nxt     = 1'b1;
            pend_lo_nxt  = sup_off[9:0];
            pend_eot_nxt = q_rd_ent.eot;
          end
          ENT_ERROR: begin
            unit_nxt = '0;
            err_nxt  = 1'b1;
            last_nxt = 1'b1;
            done_nxt = 1'b1;
          end
          default: begin
            unit_nxt = '0;
            err_nxt  = 1'b1;
            last_nxt = 1'b1;
            done_nxt = 1'b1;
          end
        endcase
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r     <= unit_nxt;
    err_r      <= err_nxt;
    last_r     <= last_nxt;
    done_r     <= done_nxt;
    pend_lo_r  <= pend_lo_nxt;
    pend_eot_r <= pend_eot_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24-CP_W){1'b0}}, unit_r};
  assign out_tlast  = last_r;
  assign out_tuser  = {done_r, err_r};

endmodule

// File: hdl/utf8_to_utf16_transcoder_unit.sv
// UTF-8 to UTF-16 / UTF-32 transcoder, top level.
// Path from input beat to result beat: front -> queue -> output register.
// Throughput: one input byte per cycle unless the queue is full; a surrogate pair
//   emits a high and a low beat, and the job queue (QUEUE_DEPTH entries) absorbs that.
// Reset (rst_n low, synchronous): clears text state and queue, utf16_mode returns to 1.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back.
module utf8_to_utf16_transcoder_unit import u8u16_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: utf16_mode, 1 = UTF-16 units, 0 = whole code points
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // byte stream in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // end_of_text
  // result stream out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_unit, [23:21] zero
  output logic        out_tlast,  // last_in_run
  output logic [1:0]  out_tuser   // [0] error, [1] text_done
);

  // Job handoff between front and back ends
  ent_t q_wr_ent;
  ent_t q_rd_ent;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  // Front: decodes and validates one byte per beat; stalls only on a full queue.
  u8u16_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_wr_ent    (q_wr_ent)
  );

  // Queue: decouples the byte side from result-side backpressure.
  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_ent (q_wr_ent),
    .pop    (q_pop),
    .rd_ent (q_rd_ent),
    .full   (q_full),
    .empty  (q_empty)
  );

  // Back: one result beat per cycle from the output register while out_tready is high and a result is pending.
  u8u16_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rd_ent   (q_rd_ent),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: hdl/u8u16_checker.sv
// Port-level checks for the transcoder result stream, bound to the top.
// Depends on utf8_to_utf16_transcoder_unit port names only.
module u8u16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // error beat: zero unit, ends run and text
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[20:0] == 21'd0 && out_tlast && out_tuser[1])
    else $error("malformed error beat");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("text_done without last_in_run");

  // only a high surrogate can be a non-final beat
  a_mid_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[20:10] == 11'b00000110110 && !out_tuser[0])
    else $error("non-final beat is not a high surrogate");

  // a taken high surrogate is followed at once by its low half
  a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && out_tlast && out_tdata[20:10] == 11'b00000110111)
    else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_transcoder_unit u8u16_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
